// File: src/cps_pkg.sv
package cps_pkg;

    // Input commands
    typedef enum logic [1:0] {
        CMD_LOAD_SAMPLE = 2'd0,
        CMD_LOAD_WEIGHT = 2'd1,
        CMD_LOAD_BIAS   = 2'd2,
        CMD_COMPUTE     = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam logic [2:0] REG_IN_CHANNELS  = 3'd0;
    localparam logic [2:0] REG_OUT_CHANNELS = 3'd1;
    localparam logic [2:0] REG_HEIGHT       = 3'd2;
    localparam logic [2:0] REG_WIDTH        = 3'd3;
    localparam logic [2:0] REG_STRIDE_TWO   = 3'd4;
    localparam logic [2:0] REG_SILU_ENABLE  = 3'd5;

    localparam int CFG_W = 7;
    localparam int TAPS  = 9;
    localparam int ACC_W = 48;
    localparam int DIV_W = 53;

    localparam int DEF_MAX_IN_CHANNELS  = 16;
    localparam int DEF_MAX_OUT_CHANNELS = 64;
    localparam int DEF_MAX_HEIGHT       = 64;
    localparam int DEF_MAX_WIDTH        = 64;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch item fields, begin a compute
        logic acc_clr;   // clear accumulator and tap/channel counters
        logic mac_step;  // issue a memory read for current tap, advance
        logic add_bias;  // fold bias into accumulator
        logic div_start; // start SiLU divider
        logic div_step;  // one divider step (setup or one quotient bit)
        logic finish;    // form the result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic range_err;
        logic last_tap;
        logic div_done;
        logic silu_en;
        logic zero_ch;
    } t_dp_sts;

endpackage

// File: src/conv3x3_pad1_silu_top.sv
// One compute item walks 9*in_channels taps through the single
// multiply-accumulate loop (sample and weight memories read once per tap),
// plus setup, pipeline drain, bias and finish, and the bit-serial SiLU
// divider when SiLU is on. Load items write their store without going
// busy. o_busy is high while a compute is in flight and start is ignored
// then. The result sits on the outputs for exactly one cycle under o_valid;
// the receiver cannot hold it off. Stores need no clearing after reset.
module conv3x3_pad1_silu_top #(
    parameter int MAX_IN_CHANNELS  = cps_pkg::DEF_MAX_IN_CHANNELS,
    parameter int MAX_OUT_CHANNELS = cps_pkg::DEF_MAX_OUT_CHANNELS,
    parameter int MAX_HEIGHT       = cps_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH        = cps_pkg::DEF_MAX_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [6:0]         i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [5:0]         i_out_chan,
    input  logic [3:0]         i_in_chan,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_col,
    input  logic [3:0]         i_tap,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic signed [31:0] o_out_value,
    output logic [5:0]         o_out_chan_echo,
    output logic [5:0]         o_row_echo,
    output logic [5:0]         o_col_echo,
    output logic               o_range_error
);
    import cps_pkg::*;

    t_dp_cmd w_dcmd;
    t_dp_sts w_sts;

    cps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_sts   (w_sts),
        .o_cmd   (w_dcmd),
        .o_busy  (busy)
    );

    cps_datapath #(
        .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
        .MAX_HEIGHT       (MAX_HEIGHT),
        .MAX_WIDTH        (MAX_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr_en         (i_cfg_we),
        .i_wr_addr       (i_cfg_addr),
        .i_wr_data       (i_cfg_data),
        .i_start         (start),
        .i_busy          (busy),
        .i_cmd           (i_cmd),
        .i_out_chan      (i_out_chan),
        .i_in_chan       (i_in_chan),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_tap           (i_tap),
        .i_value         (i_value),
        .i_dcmd          (w_dcmd),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .o_out_value     (o_out_value),
        .o_out_chan_echo (o_out_chan_echo),
        .o_row_echo      (o_row_echo),
        .o_col_echo      (o_col_echo),
        .o_range_error   (o_range_error)
    );

endmodule

// File: src/cps_ctrl.sv
module cps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_cmd,
    input  cps_pkg::t_dp_sts i_sts,
    output cps_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);
    import cps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_MAC, S_DRAIN, S_BIAS, S_DIV, S_DONE
    } t_state;

    t_state   r_state, n_state;
    logic [1:0] r_drain, n_drain;

    // Step the sequencer
    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start && (t_cmd'(i_cmd) == CMD_COMPUTE)) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.acc_clr = 1'b1;
                if (i_sts.range_err) n_state = S_DONE;
                else if (i_sts.zero_ch) n_state = S_BIAS;
                else n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                if (i_sts.last_tap) begin
                    n_state = S_DRAIN;
                    n_drain = 2'd2;
                end
            end
            S_DRAIN: begin
                if (r_drain == 2'd0) n_state = S_BIAS;
                else n_drain = r_drain - 2'd1;
            end
            S_BIAS: begin
                o_cmd.add_bias = 1'b1;
                if (i_sts.silu_en) n_state = S_DIV;
                else n_state = S_DONE;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_DONE;
                else o_cmd.div_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_BIAS && i_sts.silu_en) o_cmd.div_start = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_cmd.finish) else $error("finish repeated");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy) else $error("load while busy");
    a_div_silu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> i_sts.silu_en) else $error("divider without SiLU");

endmodule

// File: src/cps_datapath.sv
module cps_datapath #(
    parameter int MAX_IN_CHANNELS  = cps_pkg::DEF_MAX_IN_CHANNELS,
    parameter int MAX_OUT_CHANNELS = cps_pkg::DEF_MAX_OUT_CHANNELS,
    parameter int MAX_HEIGHT       = cps_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH        = cps_pkg::DEF_MAX_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [2:0]           i_wr_addr,
    input  logic [6:0]           i_wr_data,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [1:0]           i_cmd,
    input  logic [5:0]           i_out_chan,
    input  logic [3:0]           i_in_chan,
    input  logic [5:0]           i_row,
    input  logic [5:0]           i_col,
    input  logic [3:0]           i_tap,
    input  logic signed [31:0]   i_value,
    input  cps_pkg::t_dp_cmd     i_dcmd,
    output cps_pkg::t_dp_sts     o_sts,
    output logic                 o_valid,
    output logic signed [31:0]   o_out_value,
    output logic [5:0]           o_out_chan_echo,
    output logic [5:0]           o_row_echo,
    output logic [5:0]           o_col_echo,
    output logic                 o_range_error
);
    import cps_pkg::*;

    localparam int ICW = (MAX_IN_CHANNELS  > 1) ? $clog2(MAX_IN_CHANNELS)  : 1;
    localparam int OCW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int HW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH);
    localparam int SD  = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WD  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * TAPS;
    localparam int SAW = $clog2(SD);
    localparam int WAW = $clog2(WD);
    localparam int BW  = 10; // coordinate working width, signed

    // Configuration registers
    logic [4:0] r_in_channels;
    logic [6:0] r_out_channels, r_height, r_width;
    logic       r_stride_two, r_silu_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_channels  <= 5'd1;
            r_out_channels <= 7'd1;
            r_height       <= 7'd64;
            r_width        <= 7'd64;
            r_stride_two   <= 1'b0;
            r_silu_enable  <= 1'b0;
        end else if (i_wr_en) begin
            case (i_wr_addr)
                REG_IN_CHANNELS:  r_in_channels  <= i_wr_data[4:0];
                REG_OUT_CHANNELS: r_out_channels <= i_wr_data;
                REG_HEIGHT:       r_height       <= i_wr_data;
                REG_WIDTH:        r_width        <= i_wr_data;
                REG_STRIDE_TWO:   r_stride_two   <= i_wr_data[0];
                REG_SILU_ENABLE:  r_silu_enable  <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    // Clamp sizes to the store limits and derive the output sizes for stride two
    logic [8:0] w_h, w_w, w_icn, w_ocn, w_hout, w_wout;
    always_comb begin
        w_h   = ({2'b0, r_height} > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : {2'b0, r_height};
        w_w   = ({2'b0, r_width} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {2'b0, r_width};
        w_icn = ({4'b0, r_in_channels} > 9'(MAX_IN_CHANNELS)) ?
                9'(MAX_IN_CHANNELS) : {4'b0, r_in_channels};
        w_ocn = ({2'b0, r_out_channels} > 9'(MAX_OUT_CHANNELS)) ?
                9'(MAX_OUT_CHANNELS) : {2'b0, r_out_channels};
        w_hout = r_stride_two ? ((w_h + 9'd1) >> 1) : w_h;
        w_wout = r_stride_two ? ((w_w + 9'd1) >> 1) : w_w;
    end

    // Saturate a load value to 16 bits
    logic signed [15:0] w_sat16;
    always_comb begin
        if (i_value > 32'sd32767) w_sat16 = 16'sh7fff;
        else if (i_value < -32'sd32768) w_sat16 = 16'sh8000;
        else w_sat16 = i_value[15:0];
    end

    logic w_acc_in;
    assign w_acc_in = i_start && !i_busy;

    // Stores
    logic signed [15:0] r_smem [SD];
    logic signed [15:0] r_wmem [WD];
    logic signed [31:0] r_bmem [MAX_OUT_CHANNELS];

    logic [SAW-1:0] w_s_waddr, r_s_raddr;
    logic [WAW-1:0] w_w_waddr, r_w_raddr;
    logic           w_s_we, w_w_we, w_b_we;
    logic signed [15:0] r_s_rd, r_w_rd;

    assign w_s_we = w_acc_in && (t_cmd'(i_cmd) == CMD_LOAD_SAMPLE)
                    && (32'(i_in_chan) < MAX_IN_CHANNELS) && (32'(i_row) < MAX_HEIGHT)
                    && (32'(i_col) < MAX_WIDTH);
    assign w_w_we = w_acc_in && (t_cmd'(i_cmd) == CMD_LOAD_WEIGHT)
                    && (32'(i_out_chan) < MAX_OUT_CHANNELS)
                    && (32'(i_in_chan) < MAX_IN_CHANNELS) && (i_tap < 4'(TAPS));
    assign w_b_we = w_acc_in && (t_cmd'(i_cmd) == CMD_LOAD_BIAS)
                    && (32'(i_out_chan) < MAX_OUT_CHANNELS);
    assign w_s_waddr = SAW'((32'(i_in_chan) * MAX_HEIGHT + 32'(i_row)) * MAX_WIDTH
                            + 32'(i_col));
    assign w_w_waddr = WAW'((32'(i_out_chan) * MAX_IN_CHANNELS + 32'(i_in_chan)) * TAPS
                            + 32'(i_tap));

    always_ff @(posedge i_clk) begin
        if (w_s_we) r_smem[w_s_waddr] <= w_sat16;
        r_s_rd <= r_smem[r_s_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (w_w_we) r_wmem[w_w_waddr] <= w_sat16;
        r_w_rd <= r_wmem[r_w_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (w_b_we) r_bmem[i_out_chan[OCW-1:0]] <= i_value;
    end

    // Latched request
    logic [5:0] r_oc, r_row, r_col;
    logic       r_err;
    always_ff @(posedge i_clk) begin
        if (i_dcmd.load) begin
            r_oc  <= i_out_chan;
            r_row <= i_row;
            r_col <= i_col;
        end
    end
    assign r_err = ({3'b0, r_oc} >= w_ocn) || ({3'b0, r_row} >= w_hout)
                   || ({3'b0, r_col} >= w_wout);

    // Read the channel bias ahead of its use
    logic signed [31:0] r_b_rd;
    always_ff @(posedge i_clk) begin
        r_b_rd <= r_bmem[r_oc[OCW-1:0]];
    end

    // Tap and channel walk
    logic [1:0]    r_kh, r_kw;
    logic [ICW:0]  r_ic;
    logic          w_last;
    logic signed [BW-1:0] w_ih, w_iw;
    logic          w_inb;
    always_comb begin
        w_ih = (r_stride_two ? BW'({r_row, 1'b0}) : BW'(r_row)) + BW'(r_kh) - BW'(1);
        w_iw = (r_stride_two ? BW'({r_col, 1'b0}) : BW'(r_col)) + BW'(r_kw) - BW'(1);
        w_inb = (w_ih >= 0) && (w_ih < $signed({1'b0, w_h}))
                && (w_iw >= 0) && (w_iw < $signed({1'b0, w_w}));
        w_last = (r_kh == 2'd2) && (r_kw == 2'd2) && (9'(r_ic) + 9'd1 >= w_icn);
    end

    always_ff @(posedge i_clk) begin
        if (i_dcmd.acc_clr) begin
            r_kh <= '0;
            r_kw <= '0;
            r_ic <= '0;
        end else if (i_dcmd.mac_step) begin
            r_s_raddr <= SAW'((32'(r_ic) * MAX_HEIGHT + 32'(w_ih[HW-1:0])) * MAX_WIDTH
                              + 32'(w_iw[WW-1:0]));
            r_w_raddr <= WAW'((32'(r_oc) * MAX_IN_CHANNELS + 32'(r_ic)) * TAPS
                              + 32'(r_kh) * 3 + 32'(r_kw));
            if (r_kw == 2'd2) begin
                r_kw <= '0;
                if (r_kh == 2'd2) begin
                    r_kh <= '0;
                    r_ic <= r_ic + 1'b1;
                end else begin
                    r_kh <= r_kh + 2'd1;
                end
            end else begin
                r_kw <= r_kw + 2'd1;
            end
        end
    end

    // Valid pipeline: address -> read -> multiply -> accumulate
    logic [2:0] r_vpipe;
    logic signed [31:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vpipe <= '0;
        else r_vpipe <= {r_vpipe[1:0], i_dcmd.mac_step && w_inb};
    end
    always_ff @(posedge i_clk) begin
        r_prod <= r_s_rd * r_w_rd;
    end

    // SiLU divider: q = floor(mag*2^15/(2^16+mag)), one setup step, then one bit a cycle
    logic [DIV_W-1:0] r_num, r_den, r_rem;
    logic [5:0]       r_cnt;
    logic             r_neg;
    logic [DIV_W-1:0] w_mag, w_trial;
    assign w_mag = r_acc[ACC_W-1] ? DIV_W'(-r_acc) : DIV_W'(r_acc);
    assign w_trial = {r_rem[DIV_W-2:0], r_num[DIV_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_dcmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_vpipe[2]) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end else if (i_dcmd.add_bias) begin
            r_acc <= r_acc + ACC_W'(r_b_rd);
        end
        if (i_dcmd.div_start) begin
            r_cnt <= 6'(DIV_W + 1);
        end else if (i_dcmd.div_step) begin
            if (r_cnt == 6'(DIV_W + 1)) begin
                r_neg <= r_acc[ACC_W-1];
                r_num <= w_mag << 15;
                r_den <= w_mag + DIV_W'(65536);
                r_rem <= '0;
                r_cnt <= r_cnt - 6'd1;
            end else begin
                if (w_trial >= r_den) begin
                    r_rem <= w_trial - r_den;
                    r_num <= {r_num[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_num <= {r_num[DIV_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    assign o_sts.range_err = r_err;
    assign o_sts.last_tap  = w_last;
    assign o_sts.div_done  = (r_cnt == 6'd0);
    assign o_sts.silu_en   = r_silu_enable;
    assign o_sts.zero_ch   = (w_icn == 9'd0);

    // Form the result
    logic signed [ACC_W+1:0] w_fin;
    logic signed [31:0]      w_sat32;
    always_comb begin
        if (!r_silu_enable) w_fin = (ACC_W+2)'(r_acc);
        else if (r_neg) w_fin = -$signed({2'b0, r_num[ACC_W-1:0]});
        else w_fin = (ACC_W+2)'(r_acc) - $signed({2'b0, r_num[ACC_W-1:0]});
        if (w_fin > (ACC_W+2)'(32'sh7fffffff)) w_sat32 = 32'sh7fffffff;
        else if (w_fin < -(ACC_W+2)'(64'sd2147483648)) w_sat32 = 32'sh80000000;
        else w_sat32 = w_fin[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= i_dcmd.finish;
        if (i_dcmd.finish) begin
            o_out_value     <= r_err ? 32'sd0 : w_sat32;
            o_out_chan_echo <= r_oc;
            o_row_echo      <= r_row;
            o_col_echo      <= r_col;
            o_range_error   <= r_err;
        end
    end

    a_acc_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dcmd.add_bias |-> !r_vpipe[2]) else $error("bias collides with product");
    a_valid_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result repeated");
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dcmd.div_step |-> r_cnt != 6'd0) else $error("divider overrun");

endmodule
